/* rtl/core/abff_pkg.sv */
// Shared types and constants for the allocation bitmap find-first block.
package abff_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 10;
    localparam int LIMIT_W  = 11;

    localparam int DEF_WORD_BITS = 64;
    localparam int DEF_WORDS     = 16;

    localparam logic [LIMIT_W-1:0] BITS_IN_USE_RESET = 11'd1024;
    // not-found index reads limit plus this offset
    localparam logic [LIMIT_W-1:0] NONE_OFFSET = 11'd2;

    localparam logic [OPCODE_W-1:0] OP_TEST    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SET     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLR     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SET_ALL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLR_ALL = 3'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  bit_index;
    } in_t;

    typedef struct packed {
        logic               bit_value;
        logic               index_error;
        logic               all_set;
        logic               all_clear;
        logic [LIMIT_W-1:0] first_set_index;
        logic               first_set_found;
        logic [LIMIT_W-1:0] first_clear_index;
        logic               first_clear_found;
    } out_t;

endpackage

/* rtl/core/allocation_bitmap_find_first_core.sv */
// Allocation bitmap with find-first-set / find-first-clear, top level.
//
//  channel   ports                      dir   payload
//  request   s_valid s_ready s_data     in    abff_pkg::in_t  (opcode, bit_index)
//  result    m_valid m_ready m_data     out   abff_pkg::out_t (flags, indices)
//  config    cfg_we cfg_wdata           in    bits_in_use, 11 bits
//
//  Each request passes from accept through the modify, search and encode states; a
//  new request is taken only in idle or encode, not during modify or search, as set
//  by the single read-modify-write of the word store and the search read after it.
//  Reset clears per-word live/full/nonzero flags at once; store contents are not swept.
//  A result waiting on m_ready stalls the next request in its search step.
module allocation_bitmap_find_first_core #(
    parameter int WORD_BITS = abff_pkg::DEF_WORD_BITS,
    parameter int WORDS     = abff_pkg::DEF_WORDS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [abff_pkg::LIMIT_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  abff_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output abff_pkg::out_t              m_data
);

    localparam int LW    = abff_pkg::LIMIT_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int UWW   = $clog2(WORDS + 1);
    localparam int CAP   = WORDS * WORD_BITS;
    localparam int RSH   = 16;
    localparam int RECIP = (1 << RSH) / WORD_BITS;

    localparam logic [LW-1:0]        WB_C  = LW'(WORD_BITS);
    localparam logic [15:0]          WB16  = 16'(WORD_BITS);
    localparam logic [WORD_BITS-1:0] ONES  = '1;
    localparam logic [WORD_BITS-1:0] BIT0  = WORD_BITS'(1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MODIFY = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_ENCODE = 4'b1000
    } state_t;

    // quotient by WORD_BITS via reciprocal multiply and one correction
    function automatic logic [LW-1:0] div_wb(input logic [LW-1:0] x);
        logic [LW+RSH-1:0] prod;
        logic [LW-1:0]     q;
        logic [LW-1:0]     rem;
        prod = (LW+RSH)'(x) * (LW+RSH)'(RECIP);
        q    = prod[LW+RSH-1:RSH];
        rem  = x - q * WB_C;
        if (rem >= WB_C) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    state_t state_reg, state_next;

    logic [LW-1:0]             bits_in_use_reg;
    logic [abff_pkg::OPCODE_W-1:0] op_reg;
    logic [abff_pkg::INDEX_W-1:0]  idx_reg;
    logic [AW-1:0]             word_reg;
    logic [BW-1:0]             pos_reg;
    logic [WORDS-1:0]          live_reg, full_reg, nz_reg;
    logic [UWW-1:0]            uw_reg;
    logic [BW-1:0]             rem_reg;
    logic                      rem_nz_reg;
    logic                      bv_reg, err_reg;
    logic [AW-1:0]             sw_reg, cw_reg;
    logic                      s_any_reg, c_any_reg;
    logic                      m_valid_reg;
    abff_pkg::out_t            m_data_reg;

    // limit and its word split
    logic [LW-1:0] n_lim, lim_q, lim_r;
    always_comb begin
        n_lim = (int'(bits_in_use_reg) > CAP) ? LW'(CAP) : bits_in_use_reg;
        lim_q = div_wb(n_lim);
        lim_r = n_lim - lim_q * WB_C;
    end

    // accept-side address split
    logic          acc;
    logic [LW-1:0] acc_q, acc_r;
    assign s_ready = (state_reg == ST_IDLE) || (state_reg == ST_ENCODE);
    assign acc     = s_valid && s_ready;
    always_comb begin
        acc_q = div_wb(LW'(s_data.bit_index));
        acc_r = LW'(s_data.bit_index) - acc_q * WB_C;
    end

    // memory
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]        raddr_a, raddr_b;
    logic [WORD_BITS-1:0] rd_a, rd_b;

    abff_bitmap_mem #(
        .WORD_BITS(WORD_BITS),
        .WORDS    (WORDS)
    ) u_mem (
        .aclk   (aclk),
        .we     (mem_we),
        .waddr  (word_reg),
        .wdata  (mem_wdata),
        .raddr_a(raddr_a),
        .rdata_a(rd_a),
        .raddr_b(raddr_b),
        .rdata_b(rd_b)
    );

    // modify step
    logic [WORD_BITS-1:0] cur_word, bit_mask, set_word, clr_word;
    logic                 err, bitop, bv_next;
    always_comb begin
        // words not live since a whole-map op read as their fill value
        cur_word = live_reg[word_reg] ? rd_a : (full_reg[word_reg] ? ONES : '0);
        bit_mask = BIT0 << pos_reg;
        set_word = cur_word | bit_mask;
        clr_word = cur_word & ~bit_mask;
        bitop    = (op_reg != abff_pkg::OP_SET_ALL) && (op_reg != abff_pkg::OP_CLR_ALL);
        err      = bitop && (LW'(idx_reg) >= n_lim);
        mem_we   = 1'b0;
        mem_wdata = clr_word;
        bv_next  = 1'b0;
        case (op_reg)
            abff_pkg::OP_SET_ALL: bv_next = 1'b0;
            abff_pkg::OP_CLR_ALL: bv_next = 1'b0;
            abff_pkg::OP_SET: begin
                mem_we    = (state_reg == ST_MODIFY) && !err;
                mem_wdata = set_word;
                bv_next   = !err;
            end
            abff_pkg::OP_CLR: begin
                mem_we    = (state_reg == ST_MODIFY) && !err;
                mem_wdata = clr_word;
                bv_next   = 1'b0;
            end
            default: bv_next = !err && cur_word[pos_reg];
        endcase
    end

    // search step: pick words from the summary flags
    logic [WORDS-1:0] in_use, cand_set, cand_clr;
    logic [AW-1:0]    sw_c, cw_c;
    logic             s_any_c, c_any_c, stall;
    always_comb begin
        for (int w = 0; w < WORDS; w++) begin
            in_use[w] = (UWW'(w) < uw_reg);
        end
        cand_set = nz_reg & in_use;
        cand_clr = ~full_reg & in_use;
    end

    abff_prio_enc #(.WIDTH(WORDS)) u_word_set (
        .vec(cand_set), .found(s_any_c), .idx(sw_c)
    );
    abff_prio_enc #(.WIDTH(WORDS)) u_word_clr (
        .vec(cand_clr), .found(c_any_c), .idx(cw_c)
    );

    assign stall   = m_valid_reg && !m_ready;
    assign raddr_a = (state_reg == ST_SEARCH) ? sw_c : acc_q[AW-1:0];
    assign raddr_b = cw_c;

    // encode step: bit search within the chosen words
    logic [WORD_BITS-1:0] d_set, d_clr, lmask_set, lmask_clr, v_set, v_clr;
    logic [BW-1:0]        p_set, p_clr;
    logic                 h_set, h_clr, set_found, clr_found;
    logic [15:0]          set_full_idx, clr_full_idx;
    logic [LW-1:0]        none_idx;
    abff_pkg::out_t       res;

    always_comb begin
        d_set = live_reg[sw_reg] ? rd_a : (full_reg[sw_reg] ? ONES : '0);
        d_clr = live_reg[cw_reg] ? rd_b : (full_reg[cw_reg] ? ONES : '0);
        // partial last word: drop bits at or above the limit
        lmask_set = (rem_nz_reg && (UWW'(sw_reg) == uw_reg - 1'b1)) ? ~(ONES << rem_reg) : ONES;
        lmask_clr = (rem_nz_reg && (UWW'(cw_reg) == uw_reg - 1'b1)) ? ~(ONES << rem_reg) : ONES;
        v_set = d_set & lmask_set;
        v_clr = ~d_clr & lmask_clr;
    end

    abff_prio_enc #(.WIDTH(WORD_BITS)) u_bit_set (
        .vec(v_set), .found(h_set), .idx(p_set)
    );
    abff_prio_enc #(.WIDTH(WORD_BITS)) u_bit_clr (
        .vec(v_clr), .found(h_clr), .idx(p_clr)
    );

    always_comb begin
        set_found    = s_any_reg && h_set;
        clr_found    = c_any_reg && h_clr;
        set_full_idx = 16'(sw_reg) * WB16 + 16'(p_set);
        clr_full_idx = 16'(cw_reg) * WB16 + 16'(p_clr);
        none_idx     = n_lim + abff_pkg::NONE_OFFSET;
        res.bit_value         = bv_reg;
        res.index_error       = err_reg;
        res.all_set           = !clr_found;
        res.all_clear         = !set_found;
        res.first_set_index   = set_found ? set_full_idx[LW-1:0] : none_idx;
        res.first_set_found   = set_found;
        res.first_clear_index = clr_found ? clr_full_idx[LW-1:0] : none_idx;
        res.first_clear_found = clr_found;
    end

    // control
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = acc ? ST_MODIFY : ST_IDLE;
            ST_MODIFY: state_next = ST_SEARCH;
            ST_SEARCH: state_next = stall ? ST_SEARCH : ST_ENCODE;
            ST_ENCODE: state_next = acc ? ST_MODIFY : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            bits_in_use_reg <= abff_pkg::BITS_IN_USE_RESET;
            live_reg        <= '0;
            full_reg        <= '0;
            nz_reg          <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                bits_in_use_reg <= cfg_wdata;
            end
            if (state_reg == ST_MODIFY) begin
                case (op_reg)
                    abff_pkg::OP_SET_ALL: begin
                        live_reg <= '0;
                        full_reg <= '1;
                        nz_reg   <= '1;
                    end
                    abff_pkg::OP_CLR_ALL: begin
                        live_reg <= '0;
                        full_reg <= '0;
                        nz_reg   <= '0;
                    end
                    default: begin
                        if (mem_we) begin
                            live_reg[word_reg] <= 1'b1;
                            full_reg[word_reg] <= &mem_wdata;
                            nz_reg[word_reg]   <= |mem_wdata;
                        end
                    end
                endcase
            end
            if (state_reg == ST_ENCODE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        uw_reg     <= lim_q[UWW-1:0] + UWW'(lim_r != '0);
        rem_reg    <= lim_r[BW-1:0];
        rem_nz_reg <= (lim_r != '0);
        if (acc) begin
            op_reg   <= s_data.opcode;
            idx_reg  <= s_data.bit_index;
            word_reg <= acc_q[AW-1:0];
            pos_reg  <= acc_r[BW-1:0];
        end
        if (state_reg == ST_MODIFY) begin
            bv_reg  <= bv_next;
            err_reg <= err;
        end
        if ((state_reg == ST_SEARCH) && !stall) begin
            sw_reg    <= sw_c;
            cw_reg    <= cw_c;
            s_any_reg <= s_any_c;
            c_any_reg <= c_any_c;
        end
        if (state_reg == ST_ENCODE) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_req_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_MODIFY) ##1 (state_reg == ST_SEARCH))
        else $error("request did not move through modify and search");

    a_set_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.first_set_found) |-> (m_data.first_set_index < n_lim))
        else $error("first set index at or above limit");

    a_clr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.first_clear_found) |-> (m_data.first_clear_index < n_lim))
        else $error("first clear index at or above limit");

    a_set_clr_differ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.first_set_found && m_data.first_clear_found)
            |-> (m_data.first_set_index != m_data.first_clear_index))
        else $error("same bit reported set and clear");

endmodule

/* rtl/core/abff_prio_enc.sv */
// Lowest-set-bit priority encoder.
module abff_prio_enc #(
    parameter int WIDTH = abff_pkg::DEF_WORD_BITS
) (
    input  logic [WIDTH-1:0]                           vec,
    output logic                                       found,
    output logic [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] idx
);

    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    always_comb begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = IW'(i);
            end
        end
        found = |vec;
    end

endmodule

/* rtl/core/abff_bitmap_mem.sv */
// Bitmap word store: one write port, two registered read ports.
module abff_bitmap_mem #(
    parameter int WORD_BITS = abff_pkg::DEF_WORD_BITS,
    parameter int WORDS     = abff_pkg::DEF_WORDS
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] waddr,
    input  logic [WORD_BITS-1:0]                       wdata,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] raddr_a,
    output logic [WORD_BITS-1:0]                       rdata_a,
    input  logic [(WORDS > 1 ? $clog2(WORDS) : 1)-1:0] raddr_b,
    output logic [WORD_BITS-1:0]                       rdata_b
);

    logic [WORD_BITS-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
